FILE: hw/rtl/particle_measurement_weight_update_assert.svh
// Assertion macros used by the weight update back end.
`ifndef PARTICLE_MEASUREMENT_WEIGHT_UPDATE_ASSERT_SVH
`define PARTICLE_MEASUREMENT_WEIGHT_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS

`define PMWU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PMWU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define PMWU_ASSERT(label, prop, msg)

`define PMWU_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/pmwu_pkg.sv
// Package with widths, constants, types and helpers of the weight update block.
`timescale 1ns / 1ps
`default_nettype none

package pmwu_pkg;

  localparam int PROB_FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC_BITS = 48;
  localparam int DIST_BITS        = 16;

  localparam int PROB_W   = PROB_FRAC_BITS + 1;
  localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;

  localparam int                 SQRT3_W     = 33;
  localparam logic [SQRT3_W-1:0] SQRT3_Q32   = 33'd7439101574;
  localparam int                 SCALE_SHIFT = 16;
  localparam int                 NUM_W       = DIST_BITS + SCALE_SHIFT;
  localparam int                 DEN_W       = DIST_BITS + SQRT3_W - SCALE_SHIFT;
  localparam int                 REM_W       = DEN_W + 1;
  localparam int                 DIV_CNT_W   = $clog2(PROB_FRAC_BITS);

  localparam logic [PROB_W-1:0]   PROB_ONE   = {1'b1, {PROB_FRAC_BITS{1'b0}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
  localparam logic [WEIGHT_W-1:0] MIN_WEIGHT =
    WEIGHT_W'((64'd1 << WEIGHT_FRAC_BITS) / 64'd1000000000000);

  localparam int A_LO_W     = (WEIGHT_W + 1) / 2;
  localparam int MAC_DIGITS = (WEIGHT_W + PROB_W - 1) / PROB_W;
  localparam int MAC_STEPS  = 2 * MAC_DIGITS;
  localparam int STEP_W     = $clog2(MAC_STEPS);
  localparam int PART_W     = A_LO_W + PROB_W;
  localparam int ACC_W      = 2 * WEIGHT_W;
  localparam int SH_W       = $clog2(ACC_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PROB_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_FLOOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_HIT_PENALTY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_ELEMENTS = 3'd4;

  typedef enum logic {
    BASE_FIXED  = 1'b0,
    BASE_KERNEL = 1'b1
  } base_kind_t;

  typedef struct packed {
    logic                  empty;
    logic                  last;
    logic                  pvalid;
    base_kind_t            kind;
    logic [PROB_W-1:0]     base_prob;
    logic                  use_rel;
    logic [PROB_W-1:0]     rel;
    logic [PROB_W-1:0]     conf;
    logic [PROB_W-1:0]     pfloor;
    logic [DIST_BITS-1:0]  sigma;
    logic [DIST_BITS-1:0]  err;
    logic [WEIGHT_W-1:0]   weight;
  } item_t;

  function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
    return (v > PROB_ONE) ? PROB_ONE : v;
  endfunction

  function automatic logic [PROB_W-1:0] blend(input logic [PROB_W-1:0] x,
                                              input logic [PROB_W-1:0] p);
    logic [2*PROB_W:0] acc;
    acc = (2*PROB_W+1)'(x) * (2*PROB_W+1)'(p)
        + ((2*PROB_W+1)'(PROB_ONE - x) << PROB_FRAC_BITS)
        + (2*PROB_W+1)'(PROB_ONE >> 1);
    return acc[PROB_FRAC_BITS +: PROB_W];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pmwu_front.sv
// Front end: configuration registers, request intake and classification.
`timescale 1ns / 1ps
`default_nettype none

module pmwu_front import pmwu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DIST_BITS-1:0]  measured_distance,
  input  wire logic                  has_hit,
  input  wire logic                  has_no_hit,
  input  wire logic [PROB_W-1:0]     confidence,
  input  wire logic                  predicted_valid,
  input  wire logic [DIST_BITS-1:0]  predicted_distance,
  input  wire logic                  predicted_wall,
  input  wire logic [PROB_W-1:0]     predicted_reliability,
  input  wire logic [WEIGHT_W-1:0]   particle_weight,
  input  wire logic                  last_observation,
  input  wire logic                  empty_list,
  input  wire logic                  queue_full,
  output logic                       push,
  output item_t                      push_item
);

  logic [DIST_BITS-1:0] sigma_distance;
  logic [PROB_W-1:0]    prob_floor;
  logic [DIST_BITS-1:0] max_range;
  logic [PROB_W-1:0]    no_hit_penalty;
  logic                 field_elements_present;
  logic                 in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_distance         <= DIST_BITS'(512);
      prob_floor             <= PROB_W'(655);
      max_range              <= DIST_BITS'(25600);
      no_hit_penalty         <= PROB_W'(32768);
      field_elements_present <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_SIGMA_DISTANCE: sigma_distance <= cfg_data[DIST_BITS-1:0];
        CFG_PROB_FLOOR:     prob_floor <= cfg_data;
        CFG_MAX_RANGE:      max_range <= cfg_data[DIST_BITS-1:0];
        CFG_NO_HIT_PENALTY: no_hit_penalty <= cfg_data;
        CFG_FIELD_ELEMENTS: field_elements_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;
  assign in_range = predicted_distance <= max_range;

  always_comb begin
    push_item.empty  = empty_list;
    push_item.last   = last_observation;
    push_item.pvalid = predicted_valid;
    push_item.kind   = (predicted_valid & has_hit) ? BASE_KERNEL : BASE_FIXED;
    push_item.base_prob = (has_no_hit & in_range) ? sat_prob(no_hit_penalty) : PROB_ONE;
    push_item.use_rel = field_elements_present & ~predicted_wall
                      & (has_hit | (has_no_hit & in_range));
    push_item.rel    = sat_prob(predicted_reliability);
    push_item.conf   = sat_prob(confidence);
    push_item.pfloor = sat_prob(prob_floor);
    push_item.sigma  = sigma_distance;
    push_item.err    = (measured_distance >= predicted_distance)
                     ? measured_distance - predicted_distance
                     : predicted_distance - measured_distance;
    push_item.weight = particle_weight;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pmwu_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module pmwu_queue import pmwu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       not_empty
);

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pmwu_back.sv
// Back end: kernel divider, blending, running product and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_measurement_weight_update_assert.svh"

module pmwu_back import pmwu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  item_t                     head,
  input  wire logic                 not_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WEIGHT_W-1:0]       new_weight,
  output logic                      floor_applied
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEN  = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_REL  = 9'b000010000,
    S_CONF = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t                         state;
  item_t                          item;
  logic [DEN_W-1:0]               den;
  logic [REM_W-1:0]               rem;
  logic [PROB_FRAC_BITS-1:0]      q;
  logic [DIV_CNT_W-1:0]           cnt;
  logic [PROB_W-1:0]              prob;
  logic [WEIGHT_W-1:0]            product;
  logic [WEIGHT_W-1:0]            mac_a;
  logic [WEIGHT_W-1:0]            mac_b;
  logic [ACC_W-1:0]               acc;
  logic [STEP_W-1:0]              step;
  logic                           mac_final;
  logic [WEIGHT_W-1:0]            res_weight;
  logic                           res_floor;

  logic [DIST_BITS+SQRT3_W-1:0]   den_full;
  logic [NUM_W-1:0]               num;
  logic [REM_W-1:0]               rem_sh;
  logic                           rem_ge;
  logic [REM_W-1:0]               rem_nx;
  logic [PROB_FRAC_BITS-1:0]      q_nx;
  logic [PROB_W-1:0]              kern;
  logic [PROB_W-1:0]              rel_bl;
  logic [PROB_W-1:0]              conf_bl;
  logic [PROB_W-1:0]              conf_fl;
  logic [MAC_DIGITS*PROB_W-1:0]   mac_b_pad;
  logic [A_LO_W-1:0]              a_part;
  logic [STEP_W-2:0]              digit;
  logic [PROB_W-1:0]              b_digit;
  logic [PART_W-1:0]              partial;
  logic [SH_W-1:0]                sh;
  logic [ACC_W-1:0]               acc_sum;
  logic                           mac_done;
  logic [WEIGHT_W-1:0]            mul_prod;
  logic [WEIGHT_W-1:0]            fin_w;
  logic                           out_load;

  assign den_full = (DIST_BITS+SQRT3_W)'(item.sigma) * (DIST_BITS+SQRT3_W)'(SQRT3_Q32);
  assign num      = {item.err, {SCALE_SHIFT{1'b0}}};
  assign rem_sh   = {rem[REM_W-2:0], 1'b0};
  assign rem_ge   = rem_sh >= REM_W'(den);
  assign rem_nx   = rem_ge ? rem_sh - REM_W'(den) : rem_sh;
  assign q_nx     = {q[PROB_FRAC_BITS-2:0], rem_ge};
  assign kern     = ((PROB_ONE - PROB_W'(q_nx)) > item.pfloor)
                  ? PROB_ONE - PROB_W'(q_nx) : item.pfloor;
  assign rel_bl   = blend(item.rel, prob);
  assign conf_bl  = blend(item.conf, prob);
  assign conf_fl  = (conf_bl < item.pfloor) ? item.pfloor : conf_bl;

  assign mac_b_pad = (MAC_DIGITS*PROB_W)'(mac_b);
  assign digit     = step[STEP_W-1:1];
  assign a_part    = step[0] ? A_LO_W'(mac_a[WEIGHT_W-1:A_LO_W]) : mac_a[A_LO_W-1:0];
  assign b_digit   = mac_b_pad[digit*PROB_W +: PROB_W];
  assign partial   = PART_W'(a_part) * PART_W'(b_digit);
  assign sh        = SH_W'(step[0] ? A_LO_W : 0) + SH_W'(digit) * SH_W'(PROB_W);
  assign acc_sum   = acc + (ACC_W'(partial) << sh);
  assign mac_done  = step == (mac_final ? STEP_W'(MAC_STEPS - 1) : STEP_W'(1));
  assign mul_prod  = ((acc_sum >> PROB_FRAC_BITS) > ACC_W'(WEIGHT_ONE))
                   ? WEIGHT_ONE : acc_sum[PROB_FRAC_BITS +: WEIGHT_W];
  assign fin_w     = acc_sum[WEIGHT_FRAC_BITS +: WEIGHT_W];

  assign pop      = (state == S_IDLE) && not_empty;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      product   <= WEIGHT_ONE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (not_empty) begin
            item <= head;
            if (head.empty) begin
              res_weight <= head.weight;
              res_floor  <= 1'b0;
              product    <= WEIGHT_ONE;
              state      <= S_OUT;
            end else if (!head.pvalid) begin
              if (head.last) begin
                mac_a     <= head.weight;
                mac_b     <= product;
                acc       <= '0;
                step      <= '0;
                mac_final <= 1'b1;
                state     <= S_FIN;
              end
            end else if (head.kind == BASE_KERNEL) begin
              state <= S_DEN;
            end else begin
              prob  <= head.base_prob;
              state <= S_REL;
            end
          end
        end
        S_DEN: begin
          den   <= den_full[SCALE_SHIFT +: DEN_W];
          state <= S_CHK;
        end
        S_CHK: begin
          if (item.sigma == '0) begin
            prob  <= PROB_ONE;
            state <= S_REL;
          end else if (den == '0 || DEN_W'(num) >= den) begin
            prob  <= item.pfloor;
            state <= S_REL;
          end else begin
            rem   <= REM_W'(num);
            q     <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_nx;
          q   <= q_nx;
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(PROB_FRAC_BITS - 1)) begin
            prob  <= kern;
            state <= S_REL;
          end
        end
        S_REL: begin
          if (item.use_rel) begin
            prob <= rel_bl;
          end
          state <= S_CONF;
        end
        S_CONF: begin
          prob      <= conf_fl;
          mac_a     <= product;
          mac_b     <= WEIGHT_W'(conf_fl);
          acc       <= '0;
          step      <= '0;
          mac_final <= 1'b0;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (mac_done) begin
            product <= mul_prod;
            if (item.last) begin
              mac_a     <= item.weight;
              mac_b     <= mul_prod;
              acc       <= '0;
              step      <= '0;
              mac_final <= 1'b1;
              state     <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            acc  <= acc_sum;
            step <= step + 1'b1;
          end
        end
        S_FIN: begin
          acc  <= acc_sum;
          step <= step + 1'b1;
          if (mac_done) begin
            res_weight <= (fin_w < MIN_WEIGHT) ? MIN_WEIGHT : fin_w;
            res_floor  <= fin_w < MIN_WEIGHT;
            product    <= WEIGHT_ONE;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      new_weight    <= res_weight;
      floor_applied <= res_floor;
    end
  end

  `PMWU_ASSERT(a_product_max, product <= WEIGHT_ONE, "likelihood product above one")
  `PMWU_ASSERT_IMPLY(a_div_rem, state == S_DIV, rem < REM_W'(den), "divider remainder too big")
  `PMWU_ASSERT_IMPLY(a_out_reset, state == S_OUT, product == WEIGHT_ONE, "product not reset")
  `PMWU_ASSERT_IMPLY(a_floor_val, out_valid && floor_applied, new_weight == MIN_WEIGHT, "bad floor")

endmodule

`default_nettype wire

FILE: hw/rtl/particle_measurement_weight_update.sv
// Top level of the particle measurement weight update block.
// Each request on the input channel is one sensor observation for one particle
// together with the predicted ray result. Requests move on valid and stall and
// are taken when valid is high and stall is low. A front end classifies each
// request and places it in a two-entry queue; the back end works the queue.
// Only a last observation or an empty-list request produces a result request.
// A hit observation that needs the kernel division passes through S_DEN, S_CHK,
// the one-bit-a-cycle divider S_DIV, S_REL, S_CONF and S_MUL. A hit that needs
// no division skips S_DIV, any other valid observation goes straight to S_REL,
// an invalid prediction is only taken in S_IDLE, an empty-list request goes to
// S_OUT. A last observation adds the sequential weight multiply and output load.
// The queue keeps taking requests while the back end is busy, so in_stall is
// only high when both queue entries are waiting.
// When the receiver stalls, the result stays in the output register and the
// back end waits after finishing the next result. Reset restores the register
// defaults, empties the queue and sets the running likelihood product to one.
// Configuration is to be written by the user while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module particle_measurement_weight_update import pmwu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DIST_BITS-1:0]  measured_distance,
  input  wire logic                  has_hit,
  input  wire logic                  has_no_hit,
  input  wire logic [PROB_W-1:0]     confidence,
  input  wire logic                  predicted_valid,
  input  wire logic [DIST_BITS-1:0]  predicted_distance,
  input  wire logic                  predicted_wall,
  input  wire logic [PROB_W-1:0]     predicted_reliability,
  input  wire logic [WEIGHT_W-1:0]   particle_weight,
  input  wire logic                  last_observation,
  input  wire logic                  empty_list,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WEIGHT_W-1:0]        new_weight,
  output logic                       floor_applied
);

  logic  queue_full;
  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  not_empty;

  pmwu_front u_front (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write_enable      (cfg_write_enable),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .measured_distance     (measured_distance),
    .has_hit               (has_hit),
    .has_no_hit            (has_no_hit),
    .confidence            (confidence),
    .predicted_valid       (predicted_valid),
    .predicted_distance    (predicted_distance),
    .predicted_wall        (predicted_wall),
    .predicted_reliability (predicted_reliability),
    .particle_weight       (particle_weight),
    .last_observation      (last_observation),
    .empty_list            (empty_list),
    .queue_full            (queue_full),
    .push                  (push),
    .push_item             (push_item)
  );

  pmwu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  pmwu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_weight    (new_weight),
    .floor_applied (floor_applied)
  );

endmodule

`default_nettype wire
